// ===== src/irmt_pkg.sv =====
// Shared constants, types and table functions for the IR remote multi-tap decoder.
// No dependencies; every other file in src imports this package.
package irmt_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CODE_W  = 16;
	localparam int unsigned KEY_W   = 4;
	localparam int unsigned CHAR_W  = 7;
	localparam int unsigned ACT_W   = 3;
	localparam int unsigned CNT_W   = 6;
	localparam int unsigned TAP_W   = 2;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CNT_W-1:0] FRAME_EDGES = 6'd35;
	localparam logic [CNT_W-1:0] DATA_FIRST  = 6'd18;
	localparam logic [CNT_W-1:0] DATA_LAST   = 6'd33;

	localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESHOLD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_NOMINAL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEADER_TOLERANCE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_WINDOW       = 3'd4;

	localparam logic [TIME_W-1:0] RST_BIT_THRESHOLD    = 32'd100000;
	localparam logic [TIME_W-1:0] RST_LEADER_NOMINAL   = 32'd1077325;
	localparam logic [TIME_W-1:0] RST_LEADER_TOLERANCE = 32'd77325;
	localparam logic [TIME_W-1:0] RST_MIN_GAP          = 32'd50000;
	localparam logic [TIME_W-1:0] RST_TAP_WINDOW       = 32'd30000000;

	localparam logic [KEY_W-1:0] KEY_SEND    = 4'd10;
	localparam logic [KEY_W-1:0] KEY_DELETE  = 4'd11;
	localparam logic [KEY_W-1:0] KEY_UNKNOWN = 4'd12;
	localparam logic [KEY_W-1:0] KEY_NONE    = 4'd15;
	localparam logic [KEY_W-1:0] KEY_LAST_DIGIT = 4'd9;

	localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_APPEND  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REPLACE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SEND    = 3'd4;

	localparam logic [CODE_W-1:0] CODE_DIGIT0 = 16'h00FF;
	localparam logic [CODE_W-1:0] CODE_DIGIT1 = 16'h807F;
	localparam logic [CODE_W-1:0] CODE_DIGIT2 = 16'h40BF;
	localparam logic [CODE_W-1:0] CODE_DIGIT3 = 16'hC03F;
	localparam logic [CODE_W-1:0] CODE_DIGIT4 = 16'h20DF;
	localparam logic [CODE_W-1:0] CODE_DIGIT5 = 16'hA05F;
	localparam logic [CODE_W-1:0] CODE_DIGIT6 = 16'h609F;
	localparam logic [CODE_W-1:0] CODE_DIGIT7 = 16'hE01F;
	localparam logic [CODE_W-1:0] CODE_DIGIT8 = 16'h10EF;
	localparam logic [CODE_W-1:0] CODE_DIGIT9 = 16'h906F;
	localparam logic [CODE_W-1:0] CODE_SEND   = 16'h08F7;
	localparam logic [CODE_W-1:0] CODE_DELETE = 16'h02FD;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [CHAR_W-1:0] letter;
		logic [ACT_W-1:0]  action;
		logic              digit;
		logic [TAP_W-1:0]  tap_next;
	} tap_out_t;

	function automatic logic [KEY_W-1:0] map_code(input logic [CODE_W-1:0] code);
		logic [KEY_W-1:0] k;
		case (code)
			CODE_DIGIT0: k = 4'd0;
			CODE_DIGIT1: k = 4'd1;
			CODE_DIGIT2: k = 4'd2;
			CODE_DIGIT3: k = 4'd3;
			CODE_DIGIT4: k = 4'd4;
			CODE_DIGIT5: k = 4'd5;
			CODE_DIGIT6: k = 4'd6;
			CODE_DIGIT7: k = 4'd7;
			CODE_DIGIT8: k = 4'd8;
			CODE_DIGIT9: k = 4'd9;
			CODE_SEND:   k = KEY_SEND;
			CODE_DELETE: k = KEY_DELETE;
			default:     k = KEY_UNKNOWN;
		endcase
		return k;
	endfunction

	function automatic logic [CHAR_W-1:0] letter_base(input logic [KEY_W-1:0] k);
		logic [CHAR_W-1:0] c;
		case (k)
			4'd0:    c = 7'h20;
			4'd1:    c = 7'h30;
			4'd2:    c = 7'h41;
			4'd3:    c = 7'h44;
			4'd4:    c = 7'h47;
			4'd5:    c = 7'h4A;
			4'd6:    c = 7'h4D;
			4'd7:    c = 7'h50;
			4'd8:    c = 7'h54;
			4'd9:    c = 7'h57;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

	function automatic logic [TAP_W:0] cycle_len(input logic [KEY_W-1:0] k);
		logic [TAP_W:0] n;
		case (k)
			4'd0, 4'd1: n = 3'd1;
			4'd7, 4'd9: n = 3'd4;
			default:    n = 3'd3;
		endcase
		return n;
	endfunction

endpackage

// ===== src/irmt_edge_if.sv =====
// Edge timestamp channel of the IR remote multi-tap decoder.
// Depends on irmt_pkg for the field width.
interface irmt_edge_if import irmt_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] edge_time;

	modport source(output valid, edge_time, input ready);
	modport sink(input valid, edge_time, output ready);
endinterface

// ===== src/irmt_result_if.sv =====
// Decoded key channel of the IR remote multi-tap decoder.
// Depends on irmt_pkg for the field widths.
interface irmt_result_if import irmt_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [KEY_W-1:0]  key;
	logic [CODE_W-1:0] raw_code;
	logic [CHAR_W-1:0] letter;
	logic [ACT_W-1:0]  action;

	modport source(output valid, key, raw_code, letter, action, input ready);
	modport sink(input valid, key, raw_code, letter, action, output ready);
endinterface

// ===== src/irmt_cfg_if.sv =====
// Register write channel of the IR remote multi-tap decoder.
// Depends on irmt_pkg for the index and data widths.
interface irmt_cfg_if import irmt_pkg::*; ;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [TIME_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== src/ir_remote_multitap_decoder.sv =====
// An accepted edge is registered, then the frame logic runs combinationally and the
// key result of its completing edge is registered.
// Throughput: one edge per cycle; only a stalled result register holds off new edges.
// Reset clears all frame state, sets previous key to none and restores register defaults.
// Top level; depends on irmt_pkg, the three channel interfaces and irmt_tap.
module ir_remote_multitap_decoder import irmt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	irmt_edge_if.sink     edge_in,
	irmt_result_if.source result,
	irmt_cfg_if.sink      cfg
);

	logic [TIME_W-1:0] bit_threshold_q, leader_nominal_q, leader_tolerance_q;
	logic [TIME_W-1:0] min_gap_q, tap_window_q;

	logic              valid_s1;
	logic [TIME_W-1:0] edge_time_s1;

	logic [TIME_W-1:0] last_edge_time_q, last_stored_time_q, leader_time_q, frame_end_time_q;
	logic              frame_active_q;
	logic [CNT_W-1:0]  stored_edges_q;
	logic [CODE_W-1:0] code_shift_q;
	logic [KEY_W-1:0]  previous_key_q;
	logic [TAP_W-1:0]  tap_index_q;

	logic              out_valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [CODE_W-1:0] raw_code_q;
	logic [CHAR_W-1:0] letter_q;
	logic [ACT_W-1:0]  action_q;

	logic              advance, fire;
	logic [TIME_W-1:0] gap, bit_span, interval;
	logic [TIME_W+1:0] dev;
	logic [TIME_W:0]   dev_abs;
	logic              is_leader, gap_small, store, in_data, done, in_window;
	logic [CNT_W-1:0]  edges_a, edges_b, edges_inc;
	logic              active_a;
	logic [CODE_W-1:0] code_a, code_b;
	logic [TIME_W-1:0] stored_a, leader_a;
	tap_out_t          tap_out;

	assign advance       = !out_valid_q || result.ready;
	assign fire          = valid_s1 && advance;
	assign edge_in.ready = !valid_s1 || advance;
	assign cfg.ready     = 1'b1;

	always_comb begin
		gap       = edge_time_s1 - last_edge_time_q;
		dev       = {{2{gap[TIME_W-1]}}, gap} - {2'b00, leader_nominal_q};
		dev_abs   = dev[TIME_W+1] ? (TIME_W+1)'(0) - dev[TIME_W:0] : dev[TIME_W:0];
		is_leader = dev_abs < {1'b0, leader_tolerance_q};
		gap_small = gap[TIME_W-1] || (gap <= min_gap_q);

		edges_a  = (stored_edges_q == '0) ? CNT_W'(2) : stored_edges_q;
		edges_a  = is_leader ? CNT_W'(1) : edges_a;
		active_a = is_leader || frame_active_q;
		code_a   = is_leader ? '0 : code_shift_q;
		stored_a = is_leader ? last_edge_time_q : last_stored_time_q;
		leader_a = is_leader ? edge_time_s1 : leader_time_q;

		store     = active_a && !gap_small;
		in_data   = edges_a inside {[DATA_FIRST:DATA_LAST]};
		bit_span  = is_leader ? gap : edge_time_s1 - last_stored_time_q;
		code_b    = (store && in_data) ? {code_a[CODE_W-2:0], bit_span >= bit_threshold_q}
			: code_a;
		edges_inc = edges_a + CNT_W'(1);
		done      = store && (edges_inc >= FRAME_EDGES);
		edges_b   = store ? (done ? '0 : edges_inc) : edges_a;

		interval  = leader_a - frame_end_time_q;
		in_window = interval[TIME_W-1] || (interval < tap_window_q);
	end

	irmt_tap u_tap (
		.code         (code_b),
		.previous_key (previous_key_q),
		.tap_index    (tap_index_q),
		.in_window    (in_window),
		.tap_out      (tap_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_threshold_q    <= RST_BIT_THRESHOLD;
			leader_nominal_q   <= RST_LEADER_NOMINAL;
			leader_tolerance_q <= RST_LEADER_TOLERANCE;
			min_gap_q          <= RST_MIN_GAP;
			tap_window_q       <= RST_TAP_WINDOW;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_BIT_THRESHOLD:    bit_threshold_q    <= cfg.data;
				REG_LEADER_NOMINAL:   leader_nominal_q   <= cfg.data;
				REG_LEADER_TOLERANCE: leader_tolerance_q <= cfg.data;
				REG_MIN_GAP:          min_gap_q          <= cfg.data;
				REG_TAP_WINDOW:       tap_window_q       <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (edge_in.ready) begin
			valid_s1 <= edge_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (edge_in.valid && edge_in.ready) begin
			edge_time_s1 <= edge_in.edge_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_time_q   <= '0;
			last_stored_time_q <= '0;
			leader_time_q      <= '0;
			frame_end_time_q   <= '0;
			frame_active_q     <= 1'b0;
			stored_edges_q     <= '0;
			code_shift_q       <= '0;
			previous_key_q     <= KEY_NONE;
			tap_index_q        <= '0;
		end else if (fire) begin
			last_edge_time_q   <= edge_time_s1;
			last_stored_time_q <= store ? edge_time_s1 : stored_a;
			leader_time_q      <= leader_a;
			frame_active_q     <= active_a && !done;
			stored_edges_q     <= edges_b;
			code_shift_q       <= code_b;
			if (done) begin
				frame_end_time_q <= edge_time_s1;
				if (tap_out.digit) begin
					previous_key_q <= tap_out.key;
					tap_index_q    <= tap_out.tap_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && done;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && done) begin
			key_q      <= tap_out.key;
			raw_code_q <= code_b;
			letter_q   <= tap_out.letter;
			action_q   <= tap_out.action;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.key      = key_q;
	assign result.raw_code = raw_code_q;
	assign result.letter   = letter_q;
	assign result.action   = action_q;

	// Letter actions are given for digit keys and for nothing else.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((action_q == ACT_APPEND || action_q == ACT_REPLACE)
			== (key_q <= KEY_LAST_DIGIT)))
		else $error("letter action does not match key class");

	// A digit key always carries a printable letter.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && key_q <= KEY_LAST_DIGIT) |-> (letter_q != '0))
		else $error("digit key without letter");

	// The edge count never reaches the frame length outside the completing cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		stored_edges_q < FRAME_EDGES)
		else $error("stored edge count out of range");

	// Outside a frame the count is either cleared or parked at two.
	assert property (@(posedge clk) disable iff (!arst_n)
		!frame_active_q |-> (stored_edges_q == CNT_W'(0) || stored_edges_q == CNT_W'(2)))
		else $error("edge count moved outside a frame");

	// A result is produced only by a transaction taken from the edge register.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fire))
		else $error("result without an edge");

endmodule

// ===== src/irmt_tap.sv =====
// Key lookup and multi-tap letter selection for one completed frame.
// Depends on irmt_pkg for the code table, letter tables and tap_out_t.
module irmt_tap import irmt_pkg::*; (
	input  logic [CODE_W-1:0] code,
	input  logic [KEY_W-1:0]  previous_key,
	input  logic [TAP_W-1:0]  tap_index,
	input  logic              in_window,
	output tap_out_t          tap_out
);

	logic [KEY_W-1:0] key;
	logic [TAP_W:0]   tap_inc;
	logic [TAP_W-1:0] tap_next;
	logic             is_repeat;

	always_comb begin
		key       = map_code(code);
		is_repeat = (key == previous_key) && in_window;
		tap_inc   = {1'b0, tap_index} + 3'd1;
		if (!is_repeat || tap_inc >= cycle_len(key)) begin
			tap_next = '0;
		end else begin
			tap_next = tap_inc[TAP_W-1:0];
		end

		tap_out.key      = key;
		tap_out.digit    = key <= KEY_LAST_DIGIT;
		tap_out.tap_next = tap_next;
		tap_out.letter   = '0;
		case (key)
			KEY_SEND:    tap_out.action = ACT_SEND;
			KEY_DELETE:  tap_out.action = ACT_DELETE;
			KEY_UNKNOWN: tap_out.action = ACT_NONE;
			default: begin
				tap_out.action = is_repeat ? ACT_REPLACE : ACT_APPEND;
				tap_out.letter = letter_base(key) + {{(CHAR_W-TAP_W){1'b0}}, tap_next};
			end
		endcase
	end

endmodule
